// ===== hw/rtl/mtf_pkg.sv =====
// Package for the markup tag hide filter.
// Byte constants, sequencer states and the per-item step plan.
// No dependencies.
`timescale 1ns / 1ps

package mtf_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_W     = 8'h57;
  localparam byte_t CH_G     = 8'h47;
  localparam byte_t CH_H     = 8'h48;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_SEMI  = 8'h3B;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_QUERY = 8'h3F;
  localparam byte_t CH_BANG  = 8'h21;
  localparam byte_t CH_RPAR  = 8'h29;
  localparam byte_t CH_APOS  = 8'h27;
  localparam byte_t CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_OPEN,
    ST_BODY,
    ST_CLOSE,
    ST_CHAR,
    ST_TAIL,
    ST_MARK
  } emit_state_t;

  typedef struct packed {
    logic lead;
    logic tag;
    logic chr;
    logic tail;
    logic mark;
  } steps_t;

  typedef struct packed {
    logic   go;
    logic   last;
    steps_t steps;
    byte_t  chr_byte;
  } plan_t;

  function automatic logic drops_space(byte_t b);
    return b == CH_SPACE || b == CH_COMMA || b == CH_SEMI || b == CH_DOT ||
           b == CH_QUERY || b == CH_BANG || b == CH_RPAR || b == CH_APOS ||
           b == CH_QUOTE;
  endfunction

  function automatic emit_state_t first_step(steps_t s);
    emit_state_t st;
    priority if (s.lead) st = ST_LEAD;
    else if (s.tag)      st = ST_OPEN;
    else if (s.chr)      st = ST_CHAR;
    else if (s.tail)     st = ST_TAIL;
    else if (s.mark)     st = ST_MARK;
    else                 st = ST_IDLE;
    return st;
  endfunction

endpackage

// ===== hw/rtl/mtf_in_if.sv =====
// Input channel of the markup tag hide filter: valid/ready and one text byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface mtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

// ===== hw/rtl/mtf_out_if.sv =====
// Output channel of the markup tag hide filter: valid/ready and one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface mtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output has_byte, output run_last,
                  output text_end, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input run_last,
                  input text_end, output ready);
endinterface

// ===== hw/rtl/mtf_tagbuf.sv =====
// Tag buffer memory: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module mtf_tagbuf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/mtf_parse.sv =====
// Input side: accept a byte, track tag and space state, fill the tag buffer
// and hand a step plan to the sequencer. Depends on mtf_pkg and mtf_in_if.
`timescale 1ns / 1ps

module mtf_parse #(
  parameter int TAG_MAX = 32,
  parameter int AW      = 5,
  parameter int LW      = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             busy,
  mtf_in_if.sink           text_in,
  output mtf_pkg::plan_t   plan,
  output logic [LW-1:0]    plan_n,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data
);

  logic                show_tags;
  logic                inside_tag, inside_tag_next;
  logic [LW-1:0]       tag_length, tag_length_next;
  logic                space_held, space_held_next;
  logic                just_removed, just_removed_next;
  mtf_pkg::byte_t      first0, first1;
  logic                accept;
  logic                held_eff;
  logic                hide_kind;
  mtf_pkg::byte_t      b;

  assign text_in.ready = !busy;
  assign accept        = text_in.valid && !busy;
  assign b             = text_in.in_byte;
  assign wr_addr       = tag_length[AW-1:0];
  assign wr_data       = b;
  assign plan_n        = tag_length;

  assign hide_kind = tag_length >= LW'(2) && first0 == mtf_pkg::CH_W &&
                     (first1 == mtf_pkg::CH_G || first1 == mtf_pkg::CH_H);

  always_comb begin
    held_eff          = space_held && !(just_removed && mtf_pkg::drops_space(b));
    inside_tag_next   = inside_tag;
    tag_length_next   = tag_length;
    space_held_next   = held_eff;
    just_removed_next = 1'b0;
    wr_en             = 1'b0;
    plan              = '0;
    plan.go           = accept;
    plan.last         = text_in.text_last;
    plan.chr_byte     = b;
    priority if (b == mtf_pkg::CH_LT) begin
      inside_tag_next = 1'b1;
      tag_length_next = '0;
    end else if (b == mtf_pkg::CH_GT) begin
      inside_tag_next = 1'b0;
      if (hide_kind && !show_tags) begin
        just_removed_next = 1'b1;
      end else begin
        plan.steps.lead = held_eff;
        plan.steps.tag  = 1'b1;
        space_held_next = 1'b0;
      end
    end else if (inside_tag) begin
      if (tag_length < LW'(TAG_MAX)) begin
        wr_en           = accept;
        tag_length_next = tag_length + LW'(1);
      end
    end else begin
      plan.steps.lead = held_eff;
      if (b == mtf_pkg::CH_SPACE) begin
        space_held_next = 1'b1;
      end else begin
        plan.steps.chr  = 1'b1;
        space_held_next = 1'b0;
      end
    end
    if (text_in.text_last) begin
      plan.steps.tail   = space_held_next;
      plan.steps.mark   = !(plan.steps.lead || plan.steps.tag || plan.steps.chr ||
                            space_held_next);
      inside_tag_next   = 1'b0;
      tag_length_next   = '0;
      space_held_next   = 1'b0;
      just_removed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      show_tags    <= 1'b1;
      inside_tag   <= 1'b0;
      tag_length   <= '0;
      space_held   <= 1'b0;
      just_removed <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        show_tags <= cfg_wr_data;
      end
      if (accept) begin
        inside_tag   <= inside_tag_next;
        tag_length   <= tag_length_next;
        space_held   <= space_held_next;
        just_removed <= just_removed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && tag_length == '0) begin
      first0 <= b;
    end
    if (wr_en && tag_length == LW'(1)) begin
      first1 <= b;
    end
  end

endmodule

// ===== hw/rtl/mtf_emit.sv =====
// Result sequencer: steps through held space, tag replay, text byte and end
// marker, one result per cycle into the output register while the output slot is free.
// Depends on mtf_pkg and mtf_out_if.
`timescale 1ns / 1ps

module mtf_emit #(
  parameter int AW      = 5,
  parameter int LW      = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  mtf_pkg::plan_t   plan,
  input  logic [LW-1:0]    plan_n,
  output logic             busy,
  output logic [AW-1:0]    rd_addr,
  input  logic [7:0]       rd_data,
  mtf_out_if.source        text_out
);

  mtf_pkg::emit_state_t state, state_next;
  mtf_pkg::steps_t      pend, pend_next;
  logic [AW-1:0]        idx, idx_next;
  logic [LW-1:0]        tag_n;
  mtf_pkg::byte_t       chr_byte;
  logic                 last_item;
  logic                 slot_free;
  logic                 fire;
  mtf_pkg::byte_t       res_byte;
  logic                 res_has;
  logic                 res_run;
  logic                 out_valid;
  mtf_pkg::byte_t       out_byte;
  logic                 out_has;
  logic                 out_run;
  logic                 out_end;

  assign busy               = state != mtf_pkg::ST_IDLE;
  assign rd_addr            = idx_next;
  assign slot_free          = !out_valid || text_out.ready;
  assign text_out.valid     = out_valid;
  assign text_out.out_byte  = out_byte;
  assign text_out.has_byte  = out_has;
  assign text_out.run_last  = out_run;
  assign text_out.text_end  = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtf_pkg::ST_IDLE;
      pend  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    idx_next   = idx;
    fire       = 1'b0;
    res_byte   = '0;
    res_has    = 1'b1;
    unique case (state)
      mtf_pkg::ST_IDLE: begin
        if (plan.go) begin
          pend_next  = plan.steps;
          state_next = mtf_pkg::first_step(plan.steps);
        end
      end
      mtf_pkg::ST_LEAD: begin
        res_byte = mtf_pkg::CH_SPACE;
        if (slot_free) begin
          fire           = 1'b1;
          pend_next.lead = 1'b0;
          state_next     = mtf_pkg::first_step(pend_next);
        end
      end
      mtf_pkg::ST_OPEN: begin
        res_byte = mtf_pkg::CH_LT;
        idx_next = '0;
        if (slot_free) begin
          fire       = 1'b1;
          state_next = (tag_n != '0) ? mtf_pkg::ST_BODY : mtf_pkg::ST_CLOSE;
        end
      end
      mtf_pkg::ST_BODY: begin
        res_byte = rd_data;
        if (slot_free) begin
          fire = 1'b1;
          if (LW'(idx) + LW'(1) == tag_n) begin
            state_next = mtf_pkg::ST_CLOSE;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      mtf_pkg::ST_CLOSE: begin
        res_byte = mtf_pkg::CH_GT;
        if (slot_free) begin
          fire          = 1'b1;
          pend_next.tag = 1'b0;
          state_next    = mtf_pkg::first_step(pend_next);
        end
      end
      mtf_pkg::ST_CHAR: begin
        res_byte = chr_byte;
        if (slot_free) begin
          fire          = 1'b1;
          pend_next.chr = 1'b0;
          state_next    = mtf_pkg::first_step(pend_next);
        end
      end
      mtf_pkg::ST_TAIL: begin
        res_byte = mtf_pkg::CH_SPACE;
        if (slot_free) begin
          fire           = 1'b1;
          pend_next.tail = 1'b0;
          state_next     = mtf_pkg::first_step(pend_next);
        end
      end
      mtf_pkg::ST_MARK: begin
        res_has = 1'b0;
        if (slot_free) begin
          fire           = 1'b1;
          pend_next.mark = 1'b0;
          state_next     = mtf_pkg::first_step(pend_next);
        end
      end
    endcase
    res_run = mtf_pkg::first_step(pend_next) == mtf_pkg::ST_IDLE;
  end

  // hold the item's payload for the whole sequence
  always_ff @(posedge clk) begin
    if (plan.go && state == mtf_pkg::ST_IDLE) begin
      chr_byte  <= plan.chr_byte;
      tag_n     <= plan_n;
      last_item <= plan.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (text_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= res_byte;
      out_has  <= res_has;
      out_run  <= res_run;
      out_end  <= res_run && last_item;
    end
  end

`ifndef SYNTHESIS
  a_go_only_idle: assert property (@(posedge clk) disable iff (rst)
    plan.go |-> state == mtf_pkg::ST_IDLE)
    else $error("plan issued while sequencer busy");

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    state == mtf_pkg::ST_BODY |-> LW'(idx) < tag_n)
    else $error("tag replay index beyond tag length");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |-> out_run)
    else $error("text end without run end");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_has |-> out_byte == '0 && out_run && out_end)
    else $error("malformed end marker");

  a_fire_slot: assert property (@(posedge clk) disable iff (rst)
    fire |-> slot_free && state != mtf_pkg::ST_IDLE)
    else $error("result written over an untaken result");
`endif

endmodule

// ===== hw/rtl/markup_tag_hide_filter.sv =====
// Markup tag hide filter top level. An accepted byte's plan is registered in the
// sequencer state; its first result then goes into the output register. The
// sequencer emits one result per cycle while the output is taken, and keeps the
// input not ready until a byte's results are written (a kept tag of n bytes:
// n+2 results, plus one per held space); a byte with no result leaves it ready.
// Synchronous reset clears tag, space and sequencer state and sets show_tags.
`timescale 1ns / 1ps

module markup_tag_hide_filter #(
  parameter int TAG_MAX = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  mtf_in_if.sink    text_in,
  mtf_out_if.source text_out
);

  localparam int AW = (TAG_MAX > 1) ? $clog2(TAG_MAX) : 1;
  localparam int LW = $clog2(TAG_MAX + 1);

  mtf_pkg::plan_t plan;
  logic [LW-1:0]  plan_n;
  logic           busy;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  mtf_parse #(.TAG_MAX(TAG_MAX), .AW(AW), .LW(LW)) u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (busy),
    .text_in     (text_in),
    .plan        (plan),
    .plan_n      (plan_n),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  mtf_tagbuf #(.DEPTH(TAG_MAX), .AW(AW)) u_tagbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mtf_emit #(.AW(AW), .LW(LW)) u_emit (
    .clk      (clk),
    .rst      (rst),
    .plan     (plan),
    .plan_n   (plan_n),
    .busy     (busy),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .text_out (text_out)
  );

endmodule

// ===== verif/markup_tag_hide_filter_tb.sv =====
// Testbench for markup_tag_hide_filter: drives text bytes, predicts filtered output.
// Depends on mtf_pkg, mtf_in_if, mtf_out_if and the filter RTL.
`timescale 1ns / 1ps

module markup_tag_hide_filter_tb;
  import mtf_pkg::*;

  localparam int TAG_MAX   = 32;
  localparam int CYCLE_CAP = 400000;
  localparam int SETTLE    = 8;

  typedef struct packed {
    byte_t out_byte;
    logic  has_byte;
    logic  run_last;
    logic  text_end;
  } result_t;

  class tag_filter_model;
    logic    show_tags;
    logic    inside_tag;
    byte_t   tag_buf [TAG_MAX];
    int      tag_len;
    logic    space_held;
    logic    just_removed;
    result_t pending_results[$];
    int      failures;

    function new();
      show_tags = 1'b1;
      failures  = 0;
      clear_text();
    endfunction

    function void clear_text();
      inside_tag   = 1'b0;
      tag_len      = 0;
      space_held   = 1'b0;
      just_removed = 1'b0;
    endfunction

    function void set_show(logic v);
      show_tags = v;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_byte(byte_t b, logic last);
      result_t batch[$];
      result_t r;
      logic    hide;
      if (just_removed) begin
        if (b inside {CH_SPACE, CH_COMMA, CH_SEMI, CH_DOT, CH_QUERY, CH_BANG, CH_RPAR,
                      CH_APOS, CH_QUOTE})
          space_held = 1'b0;
        just_removed = 1'b0;
      end
      r = '0;
      r.has_byte = 1'b1;
      if (b == CH_LT) begin
        inside_tag = 1'b1;
        tag_len    = 0;
      end else if (b == CH_GT) begin
        hide = tag_len >= 2 && tag_buf[0] == CH_W && (tag_buf[1] == CH_G || tag_buf[1] == CH_H);
        inside_tag = 1'b0;
        if (hide && !show_tags) begin
          just_removed = 1'b1;
        end else begin
          if (space_held) begin
            r.out_byte = CH_SPACE;
            batch.push_back(r);
            space_held = 1'b0;
          end
          r.out_byte = CH_LT;
          batch.push_back(r);
          for (int k = 0; k < tag_len; k++) begin
            r.out_byte = tag_buf[k];
            batch.push_back(r);
          end
          r.out_byte = CH_GT;
          batch.push_back(r);
        end
      end else if (inside_tag) begin
        if (tag_len < TAG_MAX) begin
          tag_buf[tag_len] = b;
          tag_len++;
        end
      end else begin
        if (space_held) begin
          r.out_byte = CH_SPACE;
          batch.push_back(r);
          space_held = 1'b0;
        end
        if (b == CH_SPACE) begin
          space_held = 1'b1;
        end else begin
          r.out_byte = b;
          batch.push_back(r);
        end
      end
      if (last) begin
        if (space_held) begin
          r.out_byte = CH_SPACE;
          batch.push_back(r);
        end
        if (batch.size() == 0) begin
          r = '0;
          batch.push_back(r);
        end
        clear_text();
      end
      if (batch.size() != 0) begin
        batch[batch.size() - 1].run_last = 1'b1;
        batch[batch.size() - 1].text_end = last;
      end
      foreach (batch[k]) pending_results.push_back(batch[k]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: out_byte %h has_byte %b", got.out_byte,
               got.has_byte);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        failures++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %b, actual %b", want.has_byte, got.has_byte);
        failures++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
        failures++;
      end
      if (got.text_end !== want.text_end) begin
        $error("text_end: expected %b, actual %b", want.text_end, got.text_end);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   phase_count;

  tag_filter_model model = new();

  mtf_in_if  text_in();
  mtf_out_if text_out();

  markup_tag_hide_filter #(.TAG_MAX(TAG_MAX)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .text_in    (text_in),
    .text_out   (text_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && text_out.valid && text_out.ready) begin
      got.out_byte = text_out.out_byte;
      got.has_byte = text_out.has_byte;
      got.run_last = text_out.run_last;
      got.text_end = text_out.text_end;
      model.check_result(got);
    end
    text_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input byte_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid     <= 1'b1;
    text_in.in_byte   <= b;
    text_in.text_last <= last;
    do @(posedge clk); while (!text_in.ready);
    model.note_byte(b, last);
    phase_count++;
  endtask

  // random text end on any byte, including mid-tag
  task automatic send_text(input byte_t b);
    send_byte(b, $urandom_range(39) == 0);
  endtask

  task automatic drain();
    text_in.valid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_show(input logic v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model.set_show(v);
  endtask

  function automatic byte_t body_byte();
    byte_t b;
    do b = byte_t'($urandom_range(1, 255)); while (b == CH_LT || b == CH_GT);
    return b;
  endfunction

  function automatic byte_t punct_byte();
    byte_t marks[9] = '{CH_SPACE, CH_COMMA, CH_SEMI, CH_DOT, CH_QUERY, CH_BANG, CH_RPAR,
                        CH_APOS, CH_QUOTE};
    return marks[$urandom_range(8)];
  endfunction

  task automatic send_tag(input int kind);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(TAG_MAX - 4, TAG_MAX + 8)
                                 : $urandom_range(0, 6);
    send_text(CH_LT);
    if (kind < 2) begin
      send_text(CH_W);
      send_text(kind == 0 ? CH_G : CH_H);
    end
    repeat (n) send_text(body_byte());
    send_text(CH_GT);
    if ($urandom_range(1)) send_text(punct_byte());
  endtask

  task automatic send_chunk();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      repeat ($urandom_range(1, 6)) send_text(byte_t'($urandom_range(8'h61, 8'h7A)));
      if ($urandom_range(1)) send_text(CH_SPACE);
    end else if (r < 48) begin
      send_text(punct_byte());
    end else if (r < 80) begin
      send_tag($urandom_range(2));
    end else if (r < 86) begin
      send_text(CH_GT);
    end else if (r < 92) begin
      send_text(CH_LT);
      repeat ($urandom_range(0, 3)) send_text(body_byte());
      send_tag($urandom_range(2));
    end else begin
      send_text(byte_t'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    text_in.valid     = 1'b0;
    text_in.in_byte   = '0;
    text_in.text_last = 1'b0;
    text_out.ready    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_show(1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(CH_W, 1'b0);
    send_byte(CH_G, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(CH_W, 1'b0);
    send_byte(CH_H, 1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(8'h51, 1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(CH_LT, 1'b1);

    write_show(1'b1);
    send_byte(CH_LT, 1'b0);
    send_byte(CH_W, 1'b0);
    send_byte(CH_G, 1'b0);
    send_byte(CH_GT, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      write_show(ph[0]);
      phase_count = 0;
      while (phase_count < 47) send_chunk();
    end

    drain();
    if (model.failures == 0 && model.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mtf_pkg.sv
hw/rtl/mtf_in_if.sv
hw/rtl/mtf_out_if.sv
hw/rtl/mtf_tagbuf.sv
hw/rtl/mtf_parse.sv
hw/rtl/mtf_emit.sv
hw/rtl/markup_tag_hide_filter.sv
verif/markup_tag_hide_filter_tb.sv
